/* design/skat_pkg.sv */
// skat_pkg: shared types, codes and sizes of the sorted key/address table
// used by skat_cell, skat_reduce and sorted_key_address_table; no dependencies
`default_nettype none

package skat_pkg;

    // field widths
    localparam int KEY_W      = 32;
    localparam int PPA_W      = 32;
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // defaults and sizes
    localparam int CAPACITY_DEF = 256;
    localparam int GROUP_SIZE   = 16;

    // request functions
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FIND   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_LOWER  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_POP    = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOOLARGE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUP_POLICY = 1'd1;

    // cell update operations
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_INS   = 2'd1;
    localparam logic [1:0] OP_DEL   = 2'd2;
    localparam logic [1:0] OP_MERGE = 2'd3;

    // cell hit selection modes
    localparam logic [1:0] SEL_NONE  = 2'd0;
    localparam logic [1:0] SEL_EQ    = 2'd1;
    localparam logic [1:0] SEL_LB    = 2'd2;
    localparam logic [1:0] SEL_FIRST = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PPA_W-1:0] ppa;
        logic             flag;
    } entry_t;

    typedef struct packed {
        logic   hit;
        entry_t ent;
    } hit_t;

    // command broadcast to every cell
    typedef struct packed {
        logic [1:0]       op;
        logic [1:0]       sel;
        logic             del_all;
        logic [KEY_W-1:0] key;
        logic [PPA_W-1:0] ppa;
        logic             flag;
    } cell_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [PPA_W-1:0]  ppa;
        logic              flag;
    } req_t;

endpackage

`default_nettype wire

/* design/skat_cell.sv */
// skat_cell: one slot of the sorted chain; holds an entry, compares it with
// the broadcast key and shifts to or from its neighbors; uses skat_pkg
`default_nettype none

module skat_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 9
) (
    input  wire logic               clk,
    input  wire skat_pkg::cell_cmd_t cmd,
    input  wire logic [CNT_W-1:0]   cnt,
    input  wire skat_pkg::entry_t   left_ent,
    input  wire logic               left_lt,
    input  wire skat_pkg::entry_t   right_ent,
    output skat_pkg::entry_t        ent,
    output logic                    lt,
    output skat_pkg::hit_t          hit
);
    import skat_pkg::*;

    localparam bit IS_FIRST = (INDEX == 0);

    entry_t ent_reg;
    entry_t ent_next;
    logic   lt_reg;
    logic   eq_reg;
    logic   valid;
    logic   match;

    // slot holds a live entry when it sits below the fill count
    assign valid = cnt > CNT_W'(INDEX);

    // compare against the request key every cycle
    always_ff @(posedge clk)
    begin
        lt_reg  <= valid && (ent_reg.key < cmd.key);
        eq_reg  <= valid && (ent_reg.key == cmd.key);
        ent_reg <= ent_next;
    end

    // entry update: open a gap, close a gap or rewrite the address
    always_comb
    begin
        ent_next = ent_reg;
        unique case (cmd.op)
            OP_NONE:
            begin
                ent_next = ent_reg;
            end
            OP_INS:
            begin
                if (!lt_reg)
                begin
                    if (left_lt)
                    begin
                        ent_next.key  = cmd.key;
                        ent_next.ppa  = cmd.ppa;
                        ent_next.flag = cmd.flag;
                    end
                    else
                    begin
                        ent_next = left_ent;
                    end
                end
            end
            OP_DEL:
            begin
                if (cmd.del_all || !lt_reg)
                    ent_next = right_ent;
            end
            OP_MERGE:
            begin
                if (eq_reg)
                begin
                    ent_next.ppa  = cmd.ppa;
                    ent_next.flag = cmd.flag;
                end
            end
        endcase
    end

    // does this slot answer the request
    always_comb
    begin
        unique case (cmd.sel)
            SEL_NONE:  match = 1'b0;
            SEL_EQ:    match = eq_reg;
            SEL_LB:    match = valid && !lt_reg && left_lt;
            SEL_FIRST: match = valid && IS_FIRST;
        endcase
    end

    assign ent     = ent_reg;
    assign lt      = lt_reg;
    assign hit.hit = match;
    assign hit.ent = match ? ent_reg : '0;

endmodule

`default_nettype wire

/* design/skat_reduce.sv */
// skat_reduce: two-level or-tree, registered after its first level, that collects
// the one answering cell into a single hit word; uses skat_pkg
`default_nettype none

module skat_reduce #(
    parameter int N = 256
) (
    input  wire logic                   clk,
    input  wire skat_pkg::hit_t [N-1:0] cell_hit,
    output skat_pkg::hit_t              hit
);
    import skat_pkg::*;

    localparam int GS = GROUP_SIZE;
    localparam int NG = (N + GS - 1) / GS;
    localparam int HW = $bits(hit_t);

    logic [NG*GS*HW-1:0] padded;
    logic [HW-1:0]       grp_next [NG];
    logic [HW-1:0]       grp_reg  [NG];
    logic [HW-1:0]       hit_or;

    // pad the cell row to whole groups
    assign padded = (NG*GS*HW)'(cell_hit);

    // first level: or inside each group
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GS; j++)
                grp_next[g] = grp_next[g] | padded[(g*GS + j)*HW +: HW];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NG; g++)
            grp_reg[g] <= grp_next[g];
    end

    // second level: or across the group registers
    always_comb
    begin
        hit_or = '0;
        for (int g = 0; g < NG; g++)
            hit_or = hit_or | grp_reg[g];
    end

    assign hit = hit_t'(hit_or);

endmodule

`default_nettype wire

/* design/sorted_key_address_table.sv */
// Sorted key/address table: a row of CAPACITY cells keeps the entries in
// ascending key order, entry i in cell i. Each word is registered at
// acceptance; then every cell compares its key with the request key, a
// two-level or-tree, registered after its first level, picks the one
// answering cell, and in the update state the row shifts right (insert),
// shifts left (delete, pop) or rewrites one address (duplicate with policy
// 1) while the result is loaded into the output register. The next word is
// taken in the cycle after the update; no new word is taken before then. The
// update waits while a previous result is still stalled in the output
// register. No clearing pass after reset: the fill count alone marks live
// cells.
// uses skat_pkg, skat_cell, skat_reduce
`default_nettype none

module sorted_key_address_table #(
    parameter int CAPACITY = skat_pkg::CAPACITY_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [skat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [skat_pkg::CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [skat_pkg::FUNC_W-1:0]    func,
    input  wire logic [skat_pkg::KEY_W-1:0]     key,
    input  wire logic [skat_pkg::PPA_W-1:0]     ppa,
    input  wire logic                           entry_flag,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [skat_pkg::STATUS_W-1:0]       status,
    output logic [skat_pkg::KEY_W-1:0]          hit_key,
    output logic [skat_pkg::PPA_W-1:0]          hit_ppa,
    output logic                                hit_flag,
    output logic                                drop_valid,
    output logic [skat_pkg::PPA_W-1:0]          drop_ppa,
    output logic [CNT_W-1:0]                    entry_count,
    output logic [skat_pkg::KEY_W-1:0]          low_key,
    output logic [skat_pkg::KEY_W-1:0]          high_key
);
    import skat_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_SEL  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0]       state_reg, state_next;
    req_t             req_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0] min_reg, min_next;
    logic [KEY_W-1:0] max_reg, max_next;
    logic [KEY_W-1:0] key_limit_reg;
    logic             dup_policy_reg;
    logic             out_valid_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [KEY_W-1:0]    hit_key_reg;
    logic [PPA_W-1:0]    hit_ppa_reg;
    logic                hit_flag_reg;
    logic                drop_valid_reg;
    logic [PPA_W-1:0]    drop_ppa_reg;
    logic [CNT_W-1:0]    entry_count_reg;
    logic [KEY_W-1:0]    low_key_reg;
    logic [KEY_W-1:0]    high_key_reg;

    logic                accept;
    logic                upd_go;
    hit_t                tree_hit;
    cell_cmd_t           cell_cmd;
    entry_t [CAPACITY-1:0] cell_ent;
    entry_t [CAPACITY-1:0] left_ent_w;
    entry_t [CAPACITY-1:0] right_ent_w;
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] left_lt_w;
    hit_t [CAPACITY-1:0] cell_hit;

    logic [STATUS_W-1:0] dec_status;
    logic [KEY_W-1:0]    dec_hk;
    logic [PPA_W-1:0]    dec_hp;
    logic                dec_hf;
    logic                dec_dv;
    logic [PPA_W-1:0]    dec_dp;
    logic [1:0]          dec_op;
    logic                dec_del_all;
    logic                dec_seen;
    logic [1:0]          sel_mode;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign upd_go   = (state_reg == S_UPD) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_CMP;
            S_CMP:  state_next = S_SEL;
            S_SEL:  state_next = S_UPD;
            S_UPD:  if (upd_go) state_next = S_IDLE;
        endcase
    end

    // request register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.func <= func;
            req_reg.key  <= key;
            req_reg.ppa  <= ppa;
            req_reg.flag <= entry_flag;
        end
    end

    // which cell answers for this function
    always_comb
    begin
        unique case (req_reg.func)
            FN_INSERT, FN_FIND, FN_DELETE: sel_mode = SEL_EQ;
            FN_LOWER:                      sel_mode = SEL_LB;
            FN_POP:                        sel_mode = SEL_FIRST;
            default:                       sel_mode = SEL_NONE;
        endcase
    end

    // result and row update decision
    always_comb
    begin
        dec_status  = ST_NOTFOUND;
        dec_hk      = '0;
        dec_hp      = '0;
        dec_hf      = 1'b0;
        dec_dv      = 1'b0;
        dec_dp      = '0;
        dec_op      = OP_NONE;
        dec_del_all = 1'b0;
        dec_seen    = 1'b0;
        cnt_next    = cnt_reg;
        unique case (req_reg.func)
            FN_INSERT:
            begin
                if (req_reg.key > key_limit_reg)
                begin
                    dec_status = ST_TOOLARGE;
                end
                else if (tree_hit.hit)
                begin
                    dec_status = ST_MERGED;
                    dec_dv     = 1'b1;
                    dec_seen   = 1'b1;
                    dec_hk     = req_reg.key;
                    if (dup_policy_reg)
                    begin
                        dec_dp = tree_hit.ent.ppa;
                        dec_hp = req_reg.ppa;
                        dec_hf = req_reg.flag;
                        dec_op = OP_MERGE;
                    end
                    else
                    begin
                        dec_dp = req_reg.ppa;
                        dec_hp = tree_hit.ent.ppa;
                        dec_hf = tree_hit.ent.flag;
                    end
                end
                else if (cnt_reg == CNT_W'(CAPACITY))
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_status = ST_INSERTED;
                    dec_op     = OP_INS;
                    dec_seen   = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            FN_FIND, FN_LOWER, FN_DELETE, FN_POP:
            begin
                if (cnt_reg == '0)
                begin
                    dec_status = ST_EMPTY;
                end
                else if (tree_hit.hit)
                begin
                    dec_status = ST_FOUND;
                    dec_hk     = tree_hit.ent.key;
                    dec_hp     = tree_hit.ent.ppa;
                    dec_hf     = tree_hit.ent.flag;
                    if (req_reg.func == FN_DELETE || req_reg.func == FN_POP)
                    begin
                        dec_op      = OP_DEL;
                        dec_del_all = (req_reg.func == FN_POP);
                        cnt_next    = cnt_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                dec_status = ST_NOTFOUND;
            end
        endcase
    end

    // key range tracking
    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (dec_seen)
        begin
            if (req_reg.key < min_reg) min_next = req_reg.key;
            if (req_reg.key > max_reg) max_next = req_reg.key;
        end
    end

    // command broadcast to the row
    always_comb
    begin
        cell_cmd.op      = upd_go ? dec_op : OP_NONE;
        cell_cmd.sel     = sel_mode;
        cell_cmd.del_all = dec_del_all;
        cell_cmd.key     = req_reg.key;
        cell_cmd.ppa     = req_reg.ppa;
        cell_cmd.flag    = req_reg.flag;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            min_reg        <= '1;
            max_reg        <= '0;
            key_limit_reg  <= KEY_W'(32'hFFFF_FFFE);
            dup_policy_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (upd_go)
            begin
                cnt_reg <= cnt_next;
                min_reg <= min_next;
                max_reg <= max_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KEY_LIMIT:  key_limit_reg  <= cfg_data[KEY_W-1:0];
                    REG_DUP_POLICY: dup_policy_reg <= cfg_data[0];
                endcase
            end
            if (upd_go)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (upd_go)
        begin
            status_reg      <= dec_status;
            hit_key_reg     <= dec_hk;
            hit_ppa_reg     <= dec_hp;
            hit_flag_reg    <= dec_hf;
            drop_valid_reg  <= dec_dv;
            drop_ppa_reg    <= dec_dp;
            entry_count_reg <= cnt_next;
            low_key_reg     <= min_next;
            high_key_reg    <= max_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign hit_key     = hit_key_reg;
    assign hit_ppa     = hit_ppa_reg;
    assign hit_flag    = hit_flag_reg;
    assign drop_valid  = drop_valid_reg;
    assign drop_ppa    = drop_ppa_reg;
    assign entry_count = entry_count_reg;
    assign low_key     = low_key_reg;
    assign high_key    = high_key_reg;

    // neighbor wiring along the row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_link
        if (i == 0)
        begin : g_first
            assign left_ent_w[i] = cell_ent[i];
            assign left_lt_w[i]  = 1'b1;
        end
        else
        begin : g_mid_left
            assign left_ent_w[i] = cell_ent[i-1];
            assign left_lt_w[i]  = cell_lt[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_ent_w[i] = cell_ent[i];
        end
        else
        begin : g_mid_right
            assign right_ent_w[i] = cell_ent[i+1];
        end
    end

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        skat_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .cmd       (cell_cmd),
            .cnt       (cnt_reg),
            .left_ent  (left_ent_w[i]),
            .left_lt   (left_lt_w[i]),
            .right_ent (right_ent_w[i]),
            .ent       (cell_ent[i]),
            .lt        (cell_lt[i]),
            .hit       (cell_hit[i])
        );
    end

    // answering cell collection
    skat_reduce #(
        .N (CAPACITY)
    ) u_reduce (
        .clk      (clk),
        .cell_hit (cell_hit),
        .hit      (tree_hit)
    );

    // fill count stays within the row
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // the row and the count only change in the update cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_UPD) |=> $stable(cnt_reg))
        else $error("fill count changed outside update");

    // a full answer is only given with a full row
    assert property (@(posedge clk) disable iff (!rst_n)
        (upd_go && dec_status == ST_FULL) |-> (cnt_reg == CNT_W'(CAPACITY)))
        else $error("full reported with free cells");

    // after an accepted insert the key range is ordered
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_INSERTED || status_reg == ST_MERGED))
        |-> (low_key_reg <= high_key_reg))
        else $error("key range inverted after insert");

    // a delete or pop that finds its entry shrinks the row by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (upd_go && dec_op == OP_DEL) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("removal did not shrink the row");

endmodule

`default_nettype wire

/* verif/sorted_key_address_table_checker.sv */
// sorted_key_address_table_checker: watches the request, result and register ports of the
// sorted key/address table, keeps its own copy of the table and checks every result word
// depends on skat_pkg for widths, request functions, status codes and register indexes
module sorted_key_address_table_checker #(
    parameter int CAPACITY = skat_pkg::CAPACITY_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [skat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [skat_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic [skat_pkg::FUNC_W-1:0]     func,
    input  wire logic [skat_pkg::KEY_W-1:0]      key,
    input  wire logic [skat_pkg::PPA_W-1:0]      ppa,
    input  wire logic                            entry_flag,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic [skat_pkg::STATUS_W-1:0]   status,
    input  wire logic [skat_pkg::KEY_W-1:0]      hit_key,
    input  wire logic [skat_pkg::PPA_W-1:0]      hit_ppa,
    input  wire logic                            hit_flag,
    input  wire logic                            drop_valid,
    input  wire logic [skat_pkg::PPA_W-1:0]      drop_ppa,
    input  wire logic [CNT_W-1:0]                entry_count,
    input  wire logic [skat_pkg::KEY_W-1:0]      low_key,
    input  wire logic [skat_pkg::KEY_W-1:0]      high_key,
    output int                                   pending,
    output int                                   fail_count
);
    import skat_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    hit_key;
        logic [PPA_W-1:0]    hit_ppa;
        logic                hit_flag;
        logic                drop_valid;
        logic [PPA_W-1:0]    drop_ppa;
        logic [CNT_W-1:0]    entry_count;
        logic [KEY_W-1:0]    low_key;
        logic [KEY_W-1:0]    high_key;
    } answer_t;

    // shadow table, sorted by key, live below fill
    logic [KEY_W-1:0] tab_key [CAPACITY];
    logic [PPA_W-1:0] tab_ppa [CAPACITY];
    logic             tab_flag[CAPACITY];
    int               fill;
    logic [KEY_W-1:0] lo_seen;
    logic [KEY_W-1:0] hi_seen;
    logic [KEY_W-1:0] limit;
    logic             policy;

    answer_t answer_q[$];
    answer_t want;
    int      mismatches;

    assign fail_count = mismatches;

    // first slot whose key is not below k
    function automatic int lower_pos(logic [KEY_W-1:0] k);
        int p;
        p = 0;
        while (p < fill && tab_key[p] < k)
            p++;
        return p;
    endfunction

    // apply one request to the shadow table and return its result word
    function automatic answer_t serve_request(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                              logic [PPA_W-1:0] a, logic fl);
        answer_t r;
        int      p;
        r = '0;
        r.status = ST_NOTFOUND;
        if (f == FN_INSERT) begin
            if (k > limit) begin
                r.status = ST_TOOLARGE;
            end
            else begin
                p = lower_pos(k);
                if (p < fill && tab_key[p] == k) begin
                    // duplicate key: policy picks which address is dropped
                    r.drop_valid = 1'b1;
                    if (!policy) begin
                        r.drop_ppa = a;
                    end
                    else begin
                        r.drop_ppa  = tab_ppa[p];
                        tab_ppa[p]  = a;
                        tab_flag[p] = fl;
                    end
                    r.status   = ST_MERGED;
                    r.hit_key  = k;
                    r.hit_ppa  = tab_ppa[p];
                    r.hit_flag = tab_flag[p];
                end
                else if (fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end
                else begin
                    for (int i = fill; i > p; i--) begin
                        tab_key[i]  = tab_key[i-1];
                        tab_ppa[i]  = tab_ppa[i-1];
                        tab_flag[i] = tab_flag[i-1];
                    end
                    tab_key[p]  = k;
                    tab_ppa[p]  = a;
                    tab_flag[p] = fl;
                    fill++;
                    r.status = ST_INSERTED;
                end
                if (r.status != ST_FULL) begin
                    if (k < lo_seen)
                        lo_seen = k;
                    if (k > hi_seen)
                        hi_seen = k;
                end
            end
        end
        else if (f == FN_FIND || f == FN_LOWER || f == FN_DELETE || f == FN_POP) begin
            if (fill == 0) begin
                r.status = ST_EMPTY;
            end
            else begin
                p = (f == FN_POP) ? 0 : lower_pos(k);
                if (p >= fill || ((f == FN_FIND || f == FN_DELETE) && tab_key[p] != k)) begin
                    r.status = ST_NOTFOUND;
                end
                else begin
                    r.status   = ST_FOUND;
                    r.hit_key  = tab_key[p];
                    r.hit_ppa  = tab_ppa[p];
                    r.hit_flag = tab_flag[p];
                    if (f == FN_DELETE || f == FN_POP) begin
                        for (int i = p; i < fill - 1; i++) begin
                            tab_key[i]  = tab_key[i+1];
                            tab_ppa[i]  = tab_ppa[i+1];
                            tab_flag[i] = tab_flag[i+1];
                        end
                        fill--;
                    end
                end
            end
        end
        r.entry_count = CNT_W'(fill);
        r.low_key     = lo_seen;
        r.high_key    = hi_seen;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // per edge: register writes, then the result word, then the request word
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            answer_q.delete();
            fill       = 0;
            lo_seen    = '1;
            hi_seen    = '0;
            limit      = 32'hFFFF_FFFE;
            policy     = 1'b1;
            mismatches = 0;
            pending   <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_KEY_LIMIT:  limit  = cfg_data;
                    REG_DUP_POLICY: policy = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (answer_q.size() == 0) begin
                    $error("result word with nothing expected, status %0h", status);
                    mismatches++;
                end
                else begin
                    want = answer_q.pop_front();
                    compare_field("status", want.status, status);
                    compare_field("hit_key", want.hit_key, hit_key);
                    compare_field("hit_ppa", want.hit_ppa, hit_ppa);
                    compare_field("hit_flag", want.hit_flag, hit_flag);
                    compare_field("drop_valid", want.drop_valid, drop_valid);
                    compare_field("drop_ppa", want.drop_ppa, drop_ppa);
                    compare_field("entry_count", want.entry_count, entry_count);
                    compare_field("low_key", want.low_key, low_key);
                    compare_field("high_key", want.high_key, high_key);
                end
            end
            if (in_valid && !in_stall)
                answer_q.push_back(serve_request(func, key, ppa, entry_flag));
            pending <= answer_q.size();
        end
    end

endmodule

/* verif/sorted_key_address_table_tb.sv */
// sorted_key_address_table_tb: clock, reset, request stimulus, result stalls and verdict
// for the sorted key/address table; depends on skat_pkg, the design and the checker module
module sorted_key_address_table_tb;
    import skat_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W       = $clog2(CAPACITY_DEF + 1);
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 8;

    // function codes the block does not define
    localparam logic [FUNC_W-1:0] FN_RSVD_A = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RSVD_B = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_C = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [FUNC_W-1:0]     func;
    logic [KEY_W-1:0]      key;
    logic [PPA_W-1:0]      ppa;
    logic                  entry_flag;
    logic                  out_valid;
    logic                  out_stall;
    logic [STATUS_W-1:0]   status;
    logic [KEY_W-1:0]      hit_key;
    logic [PPA_W-1:0]      hit_ppa;
    logic                  hit_flag;
    logic                  drop_valid;
    logic [PPA_W-1:0]      drop_ppa;
    logic [CNT_W-1:0]      entry_count;
    logic [KEY_W-1:0]      low_key;
    logic [KEY_W-1:0]      high_key;

    int               pending;
    int               fail_count;
    logic             calm;
    int               hold_asks;
    logic [KEY_W-1:0] limit_now;
    logic [KEY_W-1:0] fill_keys[320];

    sorted_key_address_table uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .key(key), .ppa(ppa), .entry_flag(entry_flag),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .hit_key(hit_key), .hit_ppa(hit_ppa), .hit_flag(hit_flag),
        .drop_valid(drop_valid), .drop_ppa(drop_ppa), .entry_count(entry_count),
        .low_key(low_key), .high_key(high_key)
    );

    sorted_key_address_table_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .key(key), .ppa(ppa), .entry_flag(entry_flag),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .hit_key(hit_key), .hit_ppa(hit_ppa), .hit_flag(hit_flag),
        .drop_valid(drop_valid), .drop_ppa(drop_ppa), .entry_count(entry_count),
        .low_key(low_key), .high_key(high_key),
        .pending(pending), .fail_count(fail_count)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random stalls, or one long hold-off when asked
    initial
    begin
        int hold_seen;
        hold_seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else begin
                out_stall <= !calm && ($urandom_range(0, 99) < 17);
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // offer one request word and wait until it is taken
    task automatic offer_word(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                              logic [PPA_W-1:0] a, logic fl);
        if (!calm && $urandom_range(0, 99) < 17) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        key        <= k;
        ppa        <= a;
        entry_flag <= fl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // random request: keys mostly from a small pool, near the top and near the limit
    task automatic offer_random_word(int pool);
        logic [FUNC_W-1:0] f;
        logic [KEY_W-1:0]  k;
        longint            wide;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            f = FN_INSERT;
        else if (pick < 55)
            f = FN_FIND;
        else if (pick < 70)
            f = FN_LOWER;
        else if (pick < 85)
            f = FN_DELETE;
        else if (pick < 97)
            f = FN_POP;
        else
            f = FN_RSVD_A + FUNC_W'($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            k = $urandom_range(0, pool - 1);
        end
        else if (pick < 55) begin
            k = 32'hFFFF_FFFE - $urandom_range(0, pool - 1);
        end
        else if (pick < 75) begin
            wide = longint'(limit_now) + longint'($urandom_range(0, 4)) - 2;
            if (wide < 0)
                wide = 0;
            if (wide > 64'hFFFF_FFFE)
                wide = 64'hFFFF_FFFE;
            k = wide[KEY_W-1:0];
        end
        else begin
            k = $urandom;
            if (k == 32'hFFFF_FFFF)
                k = 32'hFFFF_FFFE;
        end
        offer_word(f, k, $urandom, 1'($urandom_range(0, 1)));
    endtask

    // stop sending and wait until every result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // write both registers while the block is idle
    task automatic write_regs(logic [KEY_W-1:0] lim, logic pol);
        cfg_we    <= 1'b1;
        cfg_index <= REG_KEY_LIMIT;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_index <= REG_DUP_POLICY;
        cfg_data  <= CFG_DATA_W'(pol);
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_now  = lim;
    endtask

    initial
    begin
        logic [KEY_W-1:0] lim;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        func       = '0;
        key        = '0;
        ppa        = '0;
        entry_flag = 1'b0;
        calm       = 1'b0;
        hold_asks  = 0;
        limit_now  = 32'hFFFF_FFFE;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, duplicates, misses, unused codes
        offer_word(FN_FIND, 32'd5, '0, 1'b0);
        offer_word(FN_LOWER, '0, '0, 1'b0);
        offer_word(FN_DELETE, 32'd5, '0, 1'b0);
        offer_word(FN_POP, '0, '0, 1'b0);
        offer_word(FN_INSERT, '0, '0, 1'b0);
        offer_word(FN_INSERT, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);
        offer_word(FN_INSERT, 32'd1000, 32'h1234_5678, 1'b1);
        offer_word(FN_INSERT, 32'd1000, 32'hABCD_EF01, 1'b0);
        offer_word(FN_FIND, 32'd1000, '0, 1'b0);
        offer_word(FN_FIND, 32'd999, '0, 1'b0);
        offer_word(FN_LOWER, 32'd1, '0, 1'b0);
        offer_word(FN_LOWER, 32'hFFFF_FFFE, '0, 1'b0);
        offer_word(FN_DELETE, 32'hFFFF_FFFE, '0, 1'b0);
        offer_word(FN_LOWER, 32'hFFFF_FFF0, '0, 1'b0);
        offer_word(FN_DELETE, 32'd7, '0, 1'b0);
        offer_word(FN_RSVD_A, 32'd1000, 32'h5555_5555, 1'b1);
        offer_word(FN_RSVD_B, 32'd1000, '0, 1'b0);
        offer_word(FN_RSVD_C, '0, '0, 1'b1);
        offer_word(FN_POP, '0, '0, 1'b0);
        settle();
        write_regs(32'd500, 1'b0);
        offer_word(FN_INSERT, 32'd501, 32'h0000_0001, 1'b1);
        offer_word(FN_INSERT, 32'hFFFF_FFFE, 32'h0000_0002, 1'b1);
        offer_word(FN_INSERT, 32'd500, 32'h0000_0003, 1'b1);
        offer_word(FN_INSERT, 32'd500, 32'h0000_0004, 1'b0);
        offer_word(FN_FIND, 32'd500, '0, 1'b0);
        settle();

        // random mixes under several register settings
        write_regs(32'hFFFF_FFFE, 1'b0);
        repeat (220) offer_random_word(32);
        settle();
        write_regs('0, 1'b1);
        repeat (150) offer_random_word(8);
        settle();
        lim = $urandom;
        if (lim == 32'hFFFF_FFFF)
            lim = 32'hFFFF_FFFE;
        write_regs(lim, 1'b0);
        repeat (220) offer_random_word(64);
        settle();

        // no idling, with one long result hold-off to back up the request side
        write_regs(32'hFFFF_FFFE, 1'b1);
        calm      <= 1'b1;
        hold_asks <= hold_asks + 1;
        repeat (200) offer_random_word(32);
        settle();
        calm <= 1'b0;

        // fill the table past capacity, probe it full, then drain it
        for (int i = 0; i < 320; i++) begin
            fill_keys[i] = (KEY_W'(i) << 20) | KEY_W'($urandom_range(0, 32'hF_FFFF));
            offer_word(FN_INSERT, fill_keys[i], $urandom, 1'($urandom_range(0, 1)));
        end
        repeat (10) offer_word(FN_INSERT, fill_keys[$urandom_range(0, 150)], $urandom,
                               1'($urandom_range(0, 1)));
        repeat (10) offer_word(FN_LOWER, $urandom_range(0, 32'h1400_0000), '0, 1'b0);
        settle();
        write_regs(32'hFFFF_FFFE, 1'b0);
        repeat (10) offer_word(FN_INSERT, fill_keys[$urandom_range(0, 150)], $urandom,
                               1'($urandom_range(0, 1)));
        offer_word(FN_INSERT, fill_keys[319] + 1, $urandom, 1'b1);
        repeat (300) offer_word(FN_POP, $urandom, $urandom, 1'($urandom_range(0, 1)));

        settle();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
